### rtl/assert_macros.svh
// Assertion macros shared by the waveform generator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/swpg_pkg.sv
// Package for the standard waveform point generator.
// Shape, status and register codes, defaults, and the sine entry function.
`timescale 1ns / 1ps
`default_nettype none

package swpg_pkg;

  localparam int MAX_POINTS_DEF   = 4096;
  localparam int SINE_ENTRIES_DEF = 1024;

  typedef enum logic [2:0] {
    SHAPE_RAMP     = 3'd0,
    SHAPE_SAWTOOTH = 3'd1,
    SHAPE_TRIANGLE = 3'd2,
    SHAPE_SQUARE   = 3'd3,
    SHAPE_SINE     = 3'd4,
    SHAPE_CUSTOM   = 3'd5
  } shape_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CFG = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SHAPE  = 2'd0,
    REG_AMPL   = 2'd1,
    REG_PERIOD = 2'd2,
    REG_POINTS = 2'd3
  } reg_idx_t;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  // Sine entry (Q1.15) from a 32-bit turn fraction; elaboration use only.
  function automatic logic signed [15:0] sine_entry(input logic [63:0] p);
    logic [63:0] quad, r, th, x, t, s, mag;
    quad = (p >> 30) & 64'd3;
    r    = p & (Q30_ONE - 64'd1);
    if (quad[0]) r = Q30_ONE - r;
    th = (r * Q30_HALF_PI) >> 30;
    x  = (th * th) >> 30;
    t  = Q30_ONE - x / 64'd110;
    t  = Q30_ONE - ((x * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x * t) >> 30) / 64'd6;
    s  = (th * t) >> 30;
    mag = (s + 64'd16384) >> 15;
    if (mag > 64'd32767) mag = 64'd32767;
    sine_entry = quad[1] ? -16'(mag) : 16'(mag);
  endfunction

endpackage

`default_nettype wire

### rtl/standard_waveform_point_generator.sv
// Standard waveform point generator, top level.
// Uses swpg_pkg, swpg_divider and assert_macros.svh.
//
// Input channel: in_valid/in_stall with in_point_index. Result channel:
// out_valid/out_stall with out_level, out_step_duration, out_last_point and
// out_status. A word moves when valid is high and stall is low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 shape,
// 1 amplitude, 2 period, 3 point count); write only while idle.
// Pipeline: three set-up stages, 16 divider stages, sine table, amplitude
// multiply, output register. One word per cycle is accepted unless a
// receiver stall holds the pipeline. The divider stages are bit-per-stage
// dividers for level, sine index and step duration.
// Reset clears all valid bits and loads shape 5 (level 0) with zero
// amplitude, period and point count, so results report bad configuration.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module standard_waveform_point_generator #(
  parameter int MAX_POINTS   = swpg_pkg::MAX_POINTS_DEF,
  parameter int SINE_ENTRIES = swpg_pkg::SINE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_point_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_level,
  output logic [15:0]      out_step_duration,
  output logic             out_last_point,
  output logic [1:0]       out_status
);

  localparam int QW    = 16;
  localparam int KW    = $clog2(SINE_ENTRIES);
  localparam int SNW   = 12 + $clog2(SINE_ENTRIES + 1);
  localparam int NSTG  = QW + 6;
  localparam int DIVO  = QW + 2;
  localparam int TSTG  = QW + 3;
  localparam int MSTG  = QW + 4;
  localparam int LAST  = QW + 5;

  typedef struct packed {
    logic                vld;
    swpg_pkg::status_t   status;
    logic                last;
    swpg_pkg::shape_t    shape;
    logic                hi;
  } ctl_t;

  // configuration
  logic [2:0]  shape_r;
  logic [15:0] ampl_r;
  logic [15:0] period_r;
  logic [12:0] points_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= 3'(swpg_pkg::SHAPE_CUSTOM);
      ampl_r   <= '0;
      period_r <= '0;
      points_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        swpg_pkg::REG_SHAPE:  shape_r  <= cfg_data[2:0];
        swpg_pkg::REG_AMPL:   ampl_r   <= cfg_data;
        swpg_pkg::REG_PERIOD: period_r <= cfg_data;
        swpg_pkg::REG_POINTS: points_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // sine table
  logic signed [15:0] sine_rom [SINE_ENTRIES];
  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sin
    localparam logic [63:0] P = (64'(k) << 32) / SINE_ENTRIES;
    assign sine_rom[k] = swpg_pkg::sine_entry(P);
  end

  logic en;
  ctl_t ctl_r [NSTG];
  ctl_t ctl_nxt;

  assign en        = !(ctl_r[LAST].vld && out_stall);
  assign in_stall  = !en;
  assign out_valid = ctl_r[LAST].vld;

  // entry stage
  logic        bad_cfg, n_le_max;
  logic [12:0] idx13;
  logic [13:0] mop_nxt;
  logic        odd_nxt;

  always_comb begin
    idx13    = 13'(in_point_index);
    n_le_max = 32'(points_r) <= MAX_POINTS;
    bad_cfg  = (points_r < 13'd2) || !n_le_max || (period_r == 16'd0);
    ctl_nxt.vld   = in_valid;
    ctl_nxt.shape = swpg_pkg::shape_t'(shape_r);
    ctl_nxt.hi    = {idx13, 1'b0} < {1'b0, points_r};
    ctl_nxt.last  = idx13 == (points_r - 13'd1);
    if (bad_cfg)                ctl_nxt.status = swpg_pkg::ST_BAD_CFG;
    else if (idx13 >= points_r) ctl_nxt.status = swpg_pkg::ST_RANGE;
    else                        ctl_nxt.status = swpg_pkg::ST_OK;
    odd_nxt = 1'b0;
    case (swpg_pkg::shape_t'(shape_r))
      swpg_pkg::SHAPE_RAMP: begin
        mop_nxt = 14'(idx13);
        odd_nxt = 1'b1;
      end
      swpg_pkg::SHAPE_SAWTOOTH: begin
        mop_nxt = 14'(points_r - 13'd1 - idx13);
        odd_nxt = 1'b1;
      end
      default: begin
        if (ctl_nxt.hi) mop_nxt = {idx13, 1'b0};
        else            mop_nxt = {points_r, 1'b0} - {idx13, 1'b0};
      end
    endcase
  end

  logic [11:0]    a_idx_r;
  logic [13:0]    a_mop_r;
  logic           a_odd_r, b_odd_r;
  logic [29:0]    b_prod_r;
  logic [SNW-1:0] b_snum_r, c_snum_r;
  logic [31:0]    c_lnum_r;
  logic [13:0]    c_lden_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_idx_r  <= in_point_index;
      a_mop_r  <= mop_nxt;
      a_odd_r  <= odd_nxt;
      b_prod_r <= 30'(ampl_r) * 30'(a_mop_r);
      b_snum_r <= SNW'(a_idx_r) * SNW'(SINE_ENTRIES);
      b_odd_r  <= a_odd_r;
      c_lnum_r <= 32'({b_prod_r, 1'b0}) +
                  32'(b_odd_r ? points_r - 13'd1 : points_r);
      c_lden_r <= b_odd_r ? {points_r - 13'd1, 1'b0} : {points_r, 1'b0};
      c_snum_r <= b_snum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_nxt;
      for (int s = 1; s < NSTG; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  logic [QW-1:0] d_lq, d_sq, d_dq;

  swpg_divider #(.NW(32), .DW(14), .QW(QW)) u_div_level (
    .clk(clk), .en(en), .num(c_lnum_r), .den(c_lden_r), .quo(d_lq)
  );

  swpg_divider #(.NW(SNW), .DW(13), .QW(QW)) u_div_sine (
    .clk(clk), .en(en), .num(c_snum_r), .den(points_r), .quo(d_sq)
  );

  swpg_divider #(.NW(16), .DW(13), .QW(QW)) u_div_dur (
    .clk(clk), .en(en), .num(period_r), .den(points_r), .quo(d_dq)
  );

  // table, multiply, output
  logic [15:0] t_off_r, t_lq_r, t_dur_r, m_lq_r, m_dur_r;
  logic [31:0] m_prod_r;
  logic [15:0] level_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      t_off_r  <= 16'(17'sd32768 + 17'(sine_rom[d_sq[KW-1:0]]));
      t_lq_r   <= d_lq;
      t_dur_r  <= (d_dq == '0) ? 16'd1 : d_dq;
      m_prod_r <= 32'(ampl_r) * 32'(t_off_r);
      m_lq_r   <= t_lq_r;
      m_dur_r  <= t_dur_r;
    end
  end

  always_comb begin
    case (ctl_r[MSTG].shape)
      swpg_pkg::SHAPE_RAMP,
      swpg_pkg::SHAPE_SAWTOOTH,
      swpg_pkg::SHAPE_TRIANGLE: level_nxt = m_lq_r;
      swpg_pkg::SHAPE_SQUARE:   level_nxt = ctl_r[MSTG].hi ? ampl_r : 16'd0;
      swpg_pkg::SHAPE_SINE:     level_nxt = 16'((m_prod_r + 32'd32768) >> 16);
      default:                  level_nxt = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_r[MSTG].status == swpg_pkg::ST_OK) begin
        out_level         <= level_nxt;
        out_step_duration <= m_dur_r;
        out_last_point    <= ctl_r[MSTG].last;
      end else begin
        out_level         <= '0;
        out_step_duration <= '0;
        out_last_point    <= 1'b0;
      end
      out_status <= ctl_r[MSTG].status;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_err_zero, out_valid && out_status != swpg_pkg::ST_OK |-> out_level == 16'd0 && out_step_duration == 16'd0 && !out_last_point, "error word carries data")
  `ASSERT_CLK(a_dur_nonzero, out_valid && out_status == swpg_pkg::ST_OK |-> out_step_duration != 16'd0, "ok word with zero duration")
  `ASSERT_CLK(a_accept_enters, in_valid && !in_stall |=> ctl_r[0].vld, "accepted word not in first stage")
  `ASSERT_ALWAYS(a_div_align, (DIVO + 1 == TSTG) && (TSTG + 1 == MSTG), "stage map broken")

endmodule

`default_nettype wire

### rtl/swpg_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; used by standard_waveform_point_generator.
`timescale 1ns / 1ps
`default_nettype none

module swpg_divider #(
  parameter int NW = 32,
  parameter int DW = 14,
  parameter int QW = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo
);

  localparam int SW = NW + DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [NW-1:0] rem_in, rem_nxt;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in, quo_nxt;
    logic [SW-1:0] dsh;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      dsh     = SW'(den_in) << B;
      ge      = SW'(rem_in) >= dsh;
      rem_nxt = ge ? NW'(SW'(rem_in) - dsh) : rem_in;
      quo_nxt = quo_in | (QW'(ge) << B);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

`default_nettype wire

### tb/sv/standard_waveform_point_generator_test.sv
// Self-checking bench for the standard waveform point generator.
// Drives point indices under random sender gaps and receiver stalls and checks
// each result word against a local integer model. Depends on swpg_pkg and the RTL.
`timescale 1ns / 1ps

module standard_waveform_point_generator_test;

  localparam int NPTS_MAX = swpg_pkg::MAX_POINTS_DEF;
  localparam int SINE_N   = swpg_pkg::SINE_ENTRIES_DEF;
  localparam int LIMIT    = 2000000;

  typedef struct packed {
    logic [15:0]       level;
    logic [15:0]       dur;
    logic              last;
    swpg_pkg::status_t status;
  } point_t;

  typedef struct {
    logic [11:0] idx;
    logic        has_exp;
    point_t      exp;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_point_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_level, out_step_duration;
  logic        out_last_point;
  logic [1:0]  out_status;

  standard_waveform_point_generator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [2:0]  m_shape = 3'd5;
  logic [15:0] m_amp = '0, m_period = '0;
  logic [12:0] m_npts = '0;
  point_t      pending_pts[$];
  int          n_errors = 0;
  int          cycles = 0;
  logic signed [15:0] sine_lut[SINE_N];

  function automatic logic signed [15:0] sine_q15(longint unsigned k);
    longint unsigned p, quad, r, th, x, t, s, mag;
    p = (k << 32) / SINE_N;
    quad = (p >> 30) & 3;
    r = p & 64'h3FFF_FFFF;
    if (quad[0]) r = 64'd1073741824 - r;
    th = (r * 64'd1686629713) >> 30;
    x = (th * th) >> 30;
    t = 64'd1073741824 - x / 110;
    t = 64'd1073741824 - ((x * t) >> 30) / 72;
    t = 64'd1073741824 - ((x * t) >> 30) / 42;
    t = 64'd1073741824 - ((x * t) >> 30) / 20;
    t = 64'd1073741824 - ((x * t) >> 30) / 6;
    s = (th * t) >> 30;
    mag = (s + 16384) >> 15;
    if (mag > 32767) mag = 32767;
    return quad[1] ? -16'(mag) : 16'(mag);
  endfunction

  function automatic point_t wave_point(logic [11:0] idx);
    point_t r;
    longint unsigned i, n, a, lv, d;
    i = idx; n = m_npts; a = m_amp; lv = 0;
    r = '{level: '0, dur: '0, last: 1'b0, status: swpg_pkg::ST_OK};
    if (n < 2 || n > NPTS_MAX || m_period == 0) begin
      r.status = swpg_pkg::ST_BAD_CFG;
      return r;
    end
    if (i >= n) begin
      r.status = swpg_pkg::ST_RANGE;
      return r;
    end
    d = m_period / n;
    if (d == 0) d = 1;
    case (m_shape)
      swpg_pkg::SHAPE_RAMP:     lv = (2*a*i + n - 1) / (2*(n - 1));
      swpg_pkg::SHAPE_SAWTOOTH: lv = (2*a*(n - 1 - i) + n - 1) / (2*(n - 1));
      swpg_pkg::SHAPE_TRIANGLE:
        lv = (2*i < n) ? (4*a*i + n) / (2*n) : (2*a*(2*n - 2*i) + n) / (2*n);
      swpg_pkg::SHAPE_SQUARE:   lv = (2*i < n) ? a : 0;
      swpg_pkg::SHAPE_SINE:
        lv = (a * longint'(32768 + sine_lut[(i * SINE_N) / n]) + 32768) >> 16;
      default:                  lv = 0;
    endcase
    r.level = lv[15:0];
    r.dur = d[15:0];
    r.last = (i == n - 1);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // receiver: stall pattern with quiet stretches
  int stall_mode = 0;
  always @(negedge clk) begin
    if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom & 3) == 0;
      2: out_stall <= ($urandom & 1) != 0;
      default: out_stall <= ($urandom & 7) != 0;
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("standard_waveform_point_generator test failed");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pts.size() == 0) begin
        report_mismatch("unexpected word, status", out_status, -1);
      end else begin
        point_t e;
        e = pending_pts.pop_front();
        if (out_level !== e.level) report_mismatch("level", out_level, e.level);
        if (out_step_duration !== e.dur) report_mismatch("step", out_step_duration, e.dur);
        if (out_last_point !== e.last) report_mismatch("last", out_last_point, e.last);
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
      end
    end
  end

  task automatic write_reg(swpg_pkg::reg_idx_t idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      swpg_pkg::REG_SHAPE:  m_shape = val[2:0];
      swpg_pkg::REG_AMPL:   m_amp = val;
      swpg_pkg::REG_PERIOD: m_period = val;
      default:              m_npts = val[12:0];
    endcase
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_pts.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_cfg(logic [2:0] sh, logic [15:0] a, logic [15:0] p, logic [12:0] n);
    drain();
    write_reg(swpg_pkg::REG_SHAPE, 16'(sh));
    write_reg(swpg_pkg::REG_AMPL, a);
    write_reg(swpg_pkg::REG_PERIOD, p);
    write_reg(swpg_pkg::REG_POINTS, 16'(n));
  endtask

  int burst_left = 0;
  // one word, presented at the falling edge and held until taken
  task automatic send_point(logic [11:0] idx, logic has_exp, point_t exp);
    point_t e;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    e = wave_point(idx);
    if (has_exp && e !== exp) report_mismatch("table entry level", exp.level, e.level);
    in_valid = 1'b1;
    in_point_index = idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pts.push_back(e);
    @(negedge clk);
    if (burst_left == 0) in_valid = 1'b0;
  endtask

  task automatic send_random(int count, int n);
    logic [11:0] idx;
    for (int k = 0; k < count; k++) begin
      if (n >= 2 && ($urandom & 15) != 0) idx = 12'($urandom_range(0, n - 1));
      else idx = 12'($urandom);
      send_point(idx, 1'b0, '0);
    end
    in_valid = 1'b0;
  endtask

  vec_t directed[$];
  int   n;

  initial begin
    for (int k = 0; k < SINE_N; k++) sine_lut[k] = sine_q15(k);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // after reset: bad configuration
    directed.push_back('{12'd0, 1'b1, '{16'd0, 16'd0, 1'b0, swpg_pkg::ST_BAD_CFG}});
    foreach (directed[k]) send_point(directed[k].idx, directed[k].has_exp, directed[k].exp);
    in_valid = 1'b0;
    // full ramp at extremes
    set_cfg(swpg_pkg::SHAPE_RAMP, 16'hFFFF, 16'hFFFF, 13'd4096);
    directed.delete();
    directed.push_back('{12'd0, 1'b1, '{16'd0, 16'd15, 1'b0, swpg_pkg::ST_OK}});
    directed.push_back('{12'd4095, 1'b1, '{16'hFFFF, 16'd15, 1'b1, swpg_pkg::ST_OK}});
    directed.push_back('{12'd2048, 1'b0, '0});
    foreach (directed[k]) send_point(directed[k].idx, directed[k].has_exp, directed[k].exp);
    in_valid = 1'b0;
    for (int sh = 1; sh < 8; sh++) begin
      set_cfg(3'(sh), 16'hFFFF, 16'd1000, 13'd2);
      directed.delete();
      directed.push_back('{12'd0, 1'b0, '0});
      directed.push_back('{12'd1, 1'b0, '0});
      directed.push_back('{12'd2, 1'b1, '{16'd0, 16'd0, 1'b0, swpg_pkg::ST_RANGE}});
      foreach (directed[k]) send_point(directed[k].idx, directed[k].has_exp, directed[k].exp);
      in_valid = 1'b0;
    end
    // short period: duration floors to 1; zero period, over-large count and a count of one fail
    set_cfg(swpg_pkg::SHAPE_SINE, 16'd0, 16'd1, 13'd7);
    send_point(12'd6, 1'b1, '{16'd0, 16'd1, 1'b1, swpg_pkg::ST_OK});
    set_cfg(swpg_pkg::SHAPE_SINE, 16'd100, 16'd0, 13'd7);
    send_point(12'd3, 1'b1, '{16'd0, 16'd0, 1'b0, swpg_pkg::ST_BAD_CFG});
    set_cfg(swpg_pkg::SHAPE_SQUARE, 16'd100, 16'd50, 13'd4097);
    send_point(12'd3, 1'b1, '{16'd0, 16'd0, 1'b0, swpg_pkg::ST_BAD_CFG});
    set_cfg(swpg_pkg::SHAPE_SQUARE, 16'd100, 16'd50, 13'd1);
    send_point(12'd0, 1'b1, '{16'd0, 16'd0, 1'b0, swpg_pkg::ST_BAD_CFG});
    in_valid = 1'b0;
    // random phases
    for (int ph = 0; ph < 35; ph++) begin
      case ($urandom_range(0, 5))
        0: n = 4096;
        1: n = $urandom_range(0, 8191);
        default: n = $urandom_range(2, 300);
      endcase
      set_cfg(3'($urandom), (ph % 5 == 0) ? 16'hFFFF : 16'($urandom),
              (ph % 7 == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)), 13'(n));
      send_random(50, n);
      if (ph == 10) drain();
    end
    drain();
    if (n_errors == 0) $display("standard_waveform_point_generator test passed");
    else $display("standard_waveform_point_generator test failed");
    $finish;
  end

endmodule
